/* hdl/hslp_pkg.sv */
// Package for the linear-probing hash set: shared constants, result type
// and the mixer constants. No dependencies.
`timescale 1ns / 1ps
package hslp_pkg;

	localparam int unsigned DEF_CAPACITY = 1024;
	localparam int unsigned KEY_W        = 64;
	localparam int unsigned SEED_W       = 10;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned COUNT_W      = 10;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic               refused_full;
		logic               inserted;
		logic               found;
	} res_t;

endpackage

/* hdl/hslp_front.sv */
// Front end of the hash set: takes items and computes the slot index with a
// pipelined splitmix64 finalizer. Depends on hslp_pkg.
`timescale 1ns / 1ps
module hslp_front import hslp_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY,
	parameter int unsigned IW       = $clog2(CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SEED_W-1:0] seed,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   in_op,
	input  logic [KEY_W-1:0]  in_key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OP_W-1:0]   out_op,
	output logic [KEY_W-1:0]  out_key,
	output logic [IW-1:0]     out_idx
);

	logic [4:0]       v_q;
	logic             en;
	logic [OP_W-1:0]  op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [KEY_W-1:0] key_s1, key_s2, key_s3, key_s4, key_s5;
	logic [63:0]      a_s1, c_s3;
	logic [63:0]      pll_s2, pll_s4;
	logic [31:0]      plh_s2, phl_s2, plh_s4, phl_s4;
	logic [IW-1:0]    idx_s5;
	logic [63:0]      h0, a_c, b_c, c_c, d_c, e_c;

	// The whole pipeline moves together; it holds when the last stage is full
	// and the queue cannot take it.
	assign en       = !v_q[4] || out_ready;
	assign in_ready = en;

	always_comb begin
		h0  = in_key ^ {{(64-SEED_W){1'b0}}, seed};
		a_c = h0 ^ (h0 >> 30);
		b_c = pll_s2 + {plh_s2 + phl_s2, 32'd0};
		c_c = b_c ^ (b_c >> 27);
		d_c = pll_s4 + {plh_s4 + phl_s4, 32'd0};
		e_c = d_c ^ (d_c >> 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= in_op;
			key_s1 <= in_key;
			a_s1   <= a_c;
			op_s2  <= op_s1;
			key_s2 <= key_s1;
			pll_s2 <= a_s1[31:0] * MIX_C1[31:0];
			plh_s2 <= 32'(a_s1[31:0] * MIX_C1[63:32]);
			phl_s2 <= 32'(a_s1[63:32] * MIX_C1[31:0]);
			op_s3  <= op_s2;
			key_s3 <= key_s2;
			c_s3   <= c_c;
			op_s4  <= op_s3;
			key_s4 <= key_s3;
			pll_s4 <= c_s3[31:0] * MIX_C2[31:0];
			plh_s4 <= 32'(c_s3[31:0] * MIX_C2[63:32]);
			phl_s4 <= 32'(c_s3[63:32] * MIX_C2[31:0]);
			op_s5  <= op_s4;
			key_s5 <= key_s4;
			idx_s5 <= e_c[IW-1:0];
		end
	end

	assign out_valid = v_q[4];
	assign out_op    = op_s5;
	assign out_key   = key_s5;
	assign out_idx   = idx_s5;

endmodule

/* hdl/hslp_fifo.sv */
// Small first-in first-out queue between the hash front end and the probe
// engine. Depends on hslp_pkg only through the import convention.
`timescale 1ns / 1ps
module hslp_fifo import hslp_pkg::*; #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [W-1:0] buf_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= wdata;
		end
	end

endmodule

/* hdl/hslp_back.sv */
// Probe engine of the hash set: owns the slot memory, walks the probe chain,
// inserts keys, runs clearing sweeps and holds the result. Depends on hslp_pkg.
`timescale 1ns / 1ps
module hslp_back import hslp_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY,
	parameter int unsigned IW       = $clog2(CAPACITY)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic [OP_W-1:0]  q_op,
	input  logic [KEY_W-1:0] q_key,
	input  logic [IW-1:0]    q_idx,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam int unsigned KCW  = $clog2(CAPACITY/2) + 1;
	localparam int unsigned SLOTS = 2**IW;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'b001,
		ST_IDLE  = 3'b010,
		ST_PROBE = 3'b100
	} state_t;

	state_t state_q;
	logic [KEY_W:0]   mem [SLOTS];
	logic [KEY_W:0]   rd_s1;
	logic [IW-1:0]    rd_addr, ptr_q, n_q, sweep_q;
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [KCW-1:0]   kc_q;
	logic             clr_res_q;
	logic             out_free, empty_hit, key_hit, done, insert_ok;
	logic             res_load;
	logic             we;
	logic [IW-1:0]    waddr;
	logic [KEY_W:0]   wdata;

	assign out_free  = !res_valid || res_ready;
	assign empty_hit = !rd_s1[KEY_W];
	assign key_hit   = rd_s1[KEY_W] && rd_s1[KEY_W-1:0] == key_q;
	assign done      = empty_hit || key_hit || (&n_q);
	assign insert_ok = op_q == OP_INSERT && empty_hit && kc_q < KCW'(CAPACITY/2);
	assign q_pop     = state_q == ST_IDLE && !q_empty;
	// A new result enters the output register, once it is free, at the end of a
	// sweep started by a clear item or when a probe finishes.
	assign res_load  = (state_q == ST_SWEEP && (&sweep_q) && clr_res_q && out_free)
		|| (state_q == ST_PROBE && done && out_free);

	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = q_idx;
			ST_PROBE: rd_addr = done ? ptr_q : ptr_q + 1'b1;
			default:  rd_addr = ptr_q;
		endcase
		we    = 1'b0;
		waddr = sweep_q;
		wdata = {1'b0, key_q};
		if (state_q == ST_SWEEP) begin
			we = 1'b1;
		end else if (state_q == ST_PROBE && done && out_free && insert_ok) begin
			we    = 1'b1;
			waddr = ptr_q;
			wdata = {1'b1, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sweep_q   <= '0;
			clr_res_q <= 1'b0;
			kc_q      <= '0;
			res_valid <= 1'b0;
			ptr_q     <= '0;
			n_q       <= '0;
			op_q      <= OP_LOOKUP;
		end else begin
			if (res_load) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (&sweep_q) begin
						if (!clr_res_q) begin
							state_q <= ST_IDLE;
							sweep_q <= '0;
						end else if (out_free) begin
							clr_res_q <= 1'b0;
							state_q   <= ST_IDLE;
							sweep_q   <= '0;
						end
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						op_q <= q_op;
						ptr_q <= q_idx;
						n_q   <= '0;
						if (q_op == OP_CLEAR) begin
							kc_q      <= '0;
							clr_res_q <= 1'b1;
							sweep_q   <= '0;
							state_q   <= ST_SWEEP;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (done) begin
						if (out_free) begin
							if (insert_ok) begin
								kc_q <= kc_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
						n_q   <= n_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_empty) begin
			key_q <= q_key;
		end
		if (state_q == ST_SWEEP && (&sweep_q) && clr_res_q && out_free) begin
			res <= '{entry_count: '0, refused_full: 1'b0, inserted: 1'b0, found: 1'b0};
		end else if (state_q == ST_PROBE && done && out_free) begin
			res.found        <= key_hit;
			res.inserted     <= insert_ok;
			res.refused_full <= op_q == OP_INSERT && !key_hit && kc_q >= KCW'(CAPACITY/2);
			res.entry_count  <= COUNT_W'(insert_ok ? kc_q + 1'b1 : kc_q);
		end
	end

endmodule

/* hdl/hash_set_linear_probe_core.sv */
// Top level of the linear-probing hash set of 64-bit keys.
// Instantiates hslp_front, hslp_fifo and hslp_back; depends on hslp_pkg.
`timescale 1ns / 1ps
// Usage:
// An item enters on the s_ channel: s_tuser carries the operation (lookup,
// insert, clear) and s_tdata the 64-bit key. Each item yields exactly one
// result item on the m_ channel: found, inserted, refused_full and the number
// of keys held afterwards, packed from bit 0 upward in m_tdata.
// The seed is written through hash_seed_we / hash_seed_wdata; the user must
// write it only while idle, as the block itself does not enforce this. The
// key is mixed in a five-stage pipeline, queued, and then probed; a lookup or
// insert walks the probe chain from its hashed slot. The probe engine reading
// one slot of the slot memory per cycle sets the rate, as long as the result
// register is free; it takes one item at a time from the queue. A clear sweeps
// the whole table before its result appears. Reset clears the control state
// and starts a sweep that empties the table; items are accepted into the queue
// meanwhile but not probed until the sweep ends. When the receiver stalls, the
// result waits in the output register, the probe engine holds, and once the
// queue and the last hash stage fill, the s_ channel drops s_tready.
module hash_set_linear_probe_core import hslp_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hash_seed_we,
	input  logic [SEED_W-1:0] hash_seed_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // [63:0] key
	input  logic [1:0]        s_tuser,   // [1:0] operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata    // [0] found, [1] inserted, [2] refused_full,
	                                     // [12:3] entry_count, [15:13] zero
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned QW = OP_W + KEY_W + IW;

	logic [SEED_W-1:0] seed_q;
	logic              f_valid, q_full, q_empty, q_pop;
	logic [OP_W-1:0]   f_op;
	logic [KEY_W-1:0]  f_key;
	logic [IW-1:0]     f_idx;
	logic [QW-1:0]     q_rdata;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (hash_seed_we) begin
			seed_q <= hash_seed_wdata;
		end
	end

	hslp_front #(.CAPACITY(CAPACITY), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n), .seed(seed_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser), .in_key(s_tdata),
		.out_valid(f_valid), .out_ready(!q_full),
		.out_op(f_op), .out_key(f_key), .out_idx(f_idx)
	);

	// Short queue so the hash pipeline and the probe engine stall on their own.
	hslp_fifo #(.W(QW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid && !q_full), .wdata({f_op, f_key, f_idx}), .full(q_full),
		.pop(q_pop), .rdata(q_rdata), .empty(q_empty)
	);

	hslp_back #(.CAPACITY(CAPACITY), .IW(IW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_pop(q_pop),
		.q_op(q_rdata[QW-1 -: OP_W]), .q_key(q_rdata[IW +: KEY_W]), .q_idx(q_rdata[IW-1:0]),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {3'b000, res.entry_count, res.refused_full, res.inserted, res.found};

endmodule

/* hdl/hslp_checker.sv */
// Port-level checks for the hash set core, bound to its top level.
// Depends on hslp_pkg and hash_set_linear_probe_core.
`timescale 1ns / 1ps
module hslp_checker import hslp_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[2]) && !(m_tdata[0] && m_tdata[1])
		&& !(m_tdata[0] && m_tdata[2]))
		else $error("result flags conflict");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[12:3] == COUNT_W'(CAPACITY/2))
		else $error("refusal below the load limit");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[12:3] != '0)
		else $error("insert reported with empty set");

endmodule

bind hash_set_linear_probe_core hslp_checker #(.CAPACITY(CAPACITY)) u_hslp_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
